[rtl/core/pox_pkg.sv]
// shared constants and types for the order crossover core
`default_nettype none

package pox_pkg;

	localparam int GENE_W        = 6;
	localparam int LEN_W         = 7;
	localparam int MAX_GENES_DEF = 64;
	localparam int NUM_GENE_VALS = 1 << GENE_W;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_START = 1'b1;

	// classified item handed from front to back
	typedef struct packed {
		logic              kind;
		logic              cut_err;
		logic [GENE_W-1:0] pos;
		logic [GENE_W-1:0] gene_a;
		logic [GENE_W-1:0] gene_b;
		logic [GENE_W-1:0] lo;
		logic [GENE_W-1:0] hi;
		logic [LEN_W-1:0]  len;
	} pox_cmd_t;

	// one child result
	typedef struct packed {
		logic [GENE_W-1:0] gene;
		logic [GENE_W-1:0] pos;
		logic              last;
		logic              err;
	} pox_res_t;

endpackage

`default_nettype wire

[rtl/core/pox_fifo.sv]
// two-entry queue used between front and back and ahead of the result ports
`default_nettype none

module pox_fifo #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/pox_front.sv]
// front end: genome length register, cut checks and item classification
`default_nettype none

module pox_front #(
	parameter int MAX_GENES = pox_pkg::MAX_GENES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pox_pkg::LEN_W-1:0] cfg_data,
	input  logic                      in_take,
	input  logic                      kind,
	input  logic [pox_pkg::GENE_W-1:0] position,
	input  logic [pox_pkg::GENE_W-1:0] first_parent_gene,
	input  logic [pox_pkg::GENE_W-1:0] second_parent_gene,
	input  logic [pox_pkg::GENE_W-1:0] cut_one,
	input  logic [pox_pkg::GENE_W-1:0] cut_two,
	output logic                      cmd_push,
	output pox_pkg::pox_cmd_t         cmd
);

	import pox_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_GENES);

	logic [LEN_W-1:0] genome_length_q;
	logic [LEN_W-1:0] len_eff;
	logic             cut_err;
	logic             swap;
	logic             pos_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			genome_length_q <= LEN_RESET;
		end else if (cfg_valid) begin
			genome_length_q <= cfg_data;
		end
	end

	always_comb begin
		len_eff = (genome_length_q > MAX_LEN) ? MAX_LEN : genome_length_q;
		cut_err = (LEN_W'(cut_one) >= len_eff) || (LEN_W'(cut_two) >= len_eff);
		swap    = cut_one > cut_two;
		pos_ok  = LEN_W'(position) < MAX_LEN;
	end

	// loads past the store depth are dropped here
	assign cmd_push = in_take && ((kind == KIND_START) || pos_ok);

	always_comb begin
		cmd.kind    = kind;
		cmd.cut_err = cut_err;
		cmd.pos     = position;
		cmd.gene_a  = first_parent_gene;
		cmd.gene_b  = second_parent_gene;
		cmd.lo      = swap ? cut_two : cut_one;
		cmd.hi      = swap ? cut_one : cut_two;
		cmd.len     = len_eff;
	end

endmodule

`default_nettype wire

[rtl/core/pox_back.sv]
// back end: parent stores, used-gene map and crossover sequencer
`default_nettype none

module pox_back #(
	parameter int MAX_GENES = pox_pkg::MAX_GENES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_empty,
	input  pox_pkg::pox_cmd_t cmd,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output pox_pkg::pox_res_t res
);

	import pox_pkg::*;

	localparam int AW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_S_RD  = 3'd1;
	localparam logic [2:0] ST_S_EM  = 3'd2;
	localparam logic [2:0] ST_P_RD  = 3'd3;
	localparam logic [2:0] ST_P_EM  = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;
	localparam logic [2:0] ST_ERR   = 3'd6;

	logic [GENE_W-1:0]        p1_mem [MAX_GENES];
	logic [GENE_W-1:0]        p2_mem [MAX_GENES];
	logic [GENE_W-1:0]        p1_rd_q;
	logic [GENE_W-1:0]        p2_rd_q;

	logic [2:0]               state_q;
	logic [AW-1:0]            idx_q;
	logic [AW-1:0]            hi_q;
	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         count_q;
	logic [NUM_GENE_VALS-1:0] used_q;
	logic                     pend_valid_q;
	logic [GENE_W-1:0]        pend_gene_q;
	logic [GENE_W-1:0]        pend_pos_q;

	logic [GENE_W-1:0]        gene;
	logic                     take;
	logic                     adv;
	logic [LEN_W-1:0]         count_nxt;
	logic                     p2_end;

	assign cmd_pop = (state_q == ST_IDLE) && !cmd_empty;

	always_ff @(posedge clk) begin
		if (cmd_pop && (cmd.kind == KIND_LOAD)) begin
			p1_mem[cmd.pos[AW-1:0]] <= cmd.gene_a;
			p2_mem[cmd.pos[AW-1:0]] <= cmd.gene_b;
		end
		p1_rd_q <= p1_mem[idx_q];
		p2_rd_q <= p2_mem[idx_q];
	end

	always_comb begin
		gene      = (state_q == ST_S_EM) ? p1_rd_q : p2_rd_q;
		take      = (state_q == ST_S_EM) || ((state_q == ST_P_EM) && !used_q[gene]);
		// a taken gene first flushes the held one, which needs room downstream
		adv       = !take || !pend_valid_q || !res_full;
		count_nxt = count_q + LEN_W'(take);
		p2_end    = (LEN_W'(idx_q) == (len_q - LEN_W'(1))) || (count_nxt >= len_q);
	end

	always_comb begin
		res_push = 1'b0;
		res.gene = pend_gene_q;
		res.pos  = pend_pos_q;
		res.last = 1'b0;
		res.err  = 1'b0;
		unique case (state_q) inside
			ST_S_EM, ST_P_EM: begin
				res_push = take && pend_valid_q && !res_full;
			end
			ST_DONE: begin
				res_push = pend_valid_q && !res_full;
				res.last = 1'b1;
			end
			ST_ERR: begin
				res_push = !res_full;
				res.gene = '0;
				res.pos  = '0;
				res.last = 1'b1;
				res.err  = 1'b1;
			end
			default: begin
				res_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take && adv) begin
			pend_gene_q <= gene;
			pend_pos_q  <= count_q[GENE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			hi_q         <= '0;
			len_q        <= '0;
			count_q      <= '0;
			used_q       <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && (cmd.kind == KIND_START)) begin
						if (cmd.cut_err) begin
							state_q <= ST_ERR;
						end else begin
							used_q  <= '0;
							idx_q   <= cmd.lo[AW-1:0];
							hi_q    <= cmd.hi[AW-1:0];
							len_q   <= cmd.len;
							count_q <= '0;
							state_q <= ST_S_RD;
						end
					end
				end
				ST_S_RD: begin
					state_q <= ST_S_EM;
				end
				ST_S_EM: begin
					if (adv) begin
						used_q[gene] <= 1'b1;
						pend_valid_q <= 1'b1;
						count_q      <= count_nxt;
						if (idx_q == hi_q) begin
							idx_q   <= '0;
							state_q <= (count_nxt >= len_q) ? ST_DONE : ST_P_RD;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_S_RD;
						end
					end
				end
				ST_P_RD: begin
					state_q <= ST_P_EM;
				end
				ST_P_EM: begin
					if (adv) begin
						if (take) begin
							used_q[gene] <= 1'b1;
							pend_valid_q <= 1'b1;
							count_q      <= count_nxt;
						end
						if (p2_end) begin
							state_q <= ST_DONE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_P_RD;
						end
					end
				end
				ST_DONE: begin
					if (!res_full) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (!res_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/permutation_order_crossover_core.sv]
// order crossover core: front end, command queue, back end and result queue
//
//   channel   direction  handshake            payload
//   input     in         push / full          kind, position, parent genes, cuts
//   result    out        empty / pop          child_gene, child_position, last_gene, cut_error
//   config    in         cfg_valid/cfg_ready  cfg_data (genome length)
//
// a load is written to the parent stores from the idle state; queued loads drain one
// per cycle while no crossover runs. a crossover reads the store for each scanned
// position, then checks and emits it, after a setup step and before a final transfer.
// reset clears queues, sequencer and used-gene map; parent stores keep no reset.
// a full result queue stalls the back end; the front keeps taking items until
// its two-entry command queue fills.
`default_nettype none

module permutation_order_crossover_core #(
	parameter int MAX_GENES = pox_pkg::MAX_GENES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       kind,
	input  logic [pox_pkg::GENE_W-1:0] position,
	input  logic [pox_pkg::GENE_W-1:0] first_parent_gene,
	input  logic [pox_pkg::GENE_W-1:0] second_parent_gene,
	input  logic [pox_pkg::GENE_W-1:0] cut_one,
	input  logic [pox_pkg::GENE_W-1:0] cut_two,
	output logic                       empty,
	input  logic                       pop,
	output logic [pox_pkg::GENE_W-1:0] child_gene,
	output logic [pox_pkg::GENE_W-1:0] child_position,
	output logic                       last_gene,
	output logic                       cut_error,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [pox_pkg::LEN_W-1:0]  cfg_data
);

	import pox_pkg::*;

	logic     in_take;
	logic     cmd_push;
	pox_cmd_t cmd_in;
	pox_cmd_t cmd_out;
	logic     cmd_full;
	logic     cmd_empty;
	logic     cmd_pop;
	logic     res_push;
	logic     res_full;
	pox_res_t res_in;
	pox_res_t res_out;

	assign full    = cmd_full;
	assign in_take = push && !cmd_full;

	pox_front #(
		.MAX_GENES(MAX_GENES)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.in_take           (in_take),
		.kind              (kind),
		.position          (position),
		.first_parent_gene (first_parent_gene),
		.second_parent_gene(second_parent_gene),
		.cut_one           (cut_one),
		.cut_two           (cut_two),
		.cmd_push          (cmd_push),
		.cmd               (cmd_in)
	);

	pox_fifo #(
		.WIDTH($bits(pox_cmd_t))
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	pox_back #(
		.MAX_GENES(MAX_GENES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd_out),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	pox_fifo #(
		.WIDTH($bits(pox_res_t))
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_out),
		.empty (empty)
	);

	assign child_gene     = res_out.gene;
	assign child_position = res_out.pos;
	assign last_gene      = res_out.last;
	assign cut_error      = res_out.err;

endmodule

`default_nettype wire

[tb/crossover_child_checker.sv]
// checker for the order crossover core: tracks parents and length, predicts child genes, compares
module crossover_child_checker #(
	parameter int MAX_GENES = pox_pkg::MAX_GENES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic                       full,
	input  logic                       kind,
	input  logic [pox_pkg::GENE_W-1:0] position,
	input  logic [pox_pkg::GENE_W-1:0] first_parent_gene,
	input  logic [pox_pkg::GENE_W-1:0] second_parent_gene,
	input  logic [pox_pkg::GENE_W-1:0] cut_one,
	input  logic [pox_pkg::GENE_W-1:0] cut_two,
	input  logic                       empty,
	input  logic                       pop,
	input  logic [pox_pkg::GENE_W-1:0] child_gene,
	input  logic [pox_pkg::GENE_W-1:0] child_position,
	input  logic                       last_gene,
	input  logic                       cut_error,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [pox_pkg::LEN_W-1:0]  cfg_data,
	output int                         mismatches,
	output int                         pending,
	output int                         children_checked
);
	import pox_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic [GENE_W-1:0]        first_store  [MAX_GENES];
	logic [GENE_W-1:0]        second_store [MAX_GENES];
	logic [NUM_GENE_VALS-1:0] used_map;
	logic [LEN_W-1:0]         genome_len;
	pox_res_t                 expected_children [$];

	// the held entry is pushed one step late so the final one can be marked
	function automatic void predict_child(input logic [GENE_W-1:0] cut_a,
			input logic [GENE_W-1:0] cut_b);
		int unsigned       len, lo, hi, cnt, i;
		logic [GENE_W-1:0] g;
		pox_res_t          held;
		len = (genome_len > MAX_GENES) ? MAX_GENES : genome_len;
		lo = cut_a;
		hi = cut_b;
		held = '0;
		if (lo >= len || hi >= len) begin
			held.last = 1'b1;
			held.err = 1'b1;
			expected_children.push_back(held);
			return;
		end
		if (lo > hi) begin
			i = lo;
			lo = hi;
			hi = i;
		end
		used_map = '0;
		cnt = 0;
		for (i = lo; i <= hi && cnt < len; i++) begin
			g = first_store[i];
			if (cnt != 0)
				expected_children.push_back(held);
			held.gene = g;
			held.pos = GENE_W'(cnt);
			held.last = 1'b0;
			held.err = 1'b0;
			used_map[g] = 1'b1;
			cnt++;
		end
		for (i = 0; i < len && cnt < len; i++) begin
			g = second_store[i];
			if (!used_map[g]) begin
				expected_children.push_back(held);
				held.gene = g;
				held.pos = GENE_W'(cnt);
				used_map[g] = 1'b1;
				cnt++;
			end
		end
		held.last = 1'b1;
		expected_children.push_back(held);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pox_res_t want;
		if (!arst_n) begin
			used_map = '0;
			genome_len = LEN_RESET;
			expected_children.delete();
			mismatches = 0;
			children_checked = 0;
		end else begin
			if (pop && !empty) begin
				children_checked++;
				if (expected_children.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected child result: gene=%0d pos=%0d last=%b err=%b",
							child_gene, child_position, last_gene, cut_error);
				end else begin
					want = expected_children.pop_front();
					if (child_gene !== want.gene || child_position !== want.pos ||
							last_gene !== want.last || cut_error !== want.err) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"child result %0d: expected gene=%0d pos=%0d last=%b err=%b,",
								" got gene=%0d pos=%0d last=%b err=%b"}, children_checked,
								want.gene, want.pos, want.last, want.err,
								child_gene, child_position, last_gene, cut_error);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				genome_len = cfg_data;
			if (push && !full) begin
				if (kind == KIND_START) begin
					predict_child(cut_one, cut_two);
				end else if (position < MAX_GENES) begin
					first_store[position] = first_parent_gene;
					second_store[position] = second_parent_gene;
				end
			end
		end
		pending = expected_children.size();
	end

endmodule

[tb/tb_top.sv]
// top of the order crossover testbench: clock, reset, stimulus and verdict
module tb_top;
	import pox_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 20;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	logic              kind = KIND_LOAD;
	logic [GENE_W-1:0] position = '0;
	logic [GENE_W-1:0] first_parent_gene = '0;
	logic [GENE_W-1:0] second_parent_gene = '0;
	logic [GENE_W-1:0] cut_one = '0;
	logic [GENE_W-1:0] cut_two = '0;
	logic              empty;
	logic              pop = 1'b0;
	logic [GENE_W-1:0] child_gene;
	logic [GENE_W-1:0] child_position;
	logic              last_gene;
	logic              cut_error;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [LEN_W-1:0]  cfg_data = '0;

	int mismatches, pending, children_checked;
	int send_idle = 28;
	int recv_idle = 58;
	int items_sent = 0;
	int mode_items = 0;
	int crossovers = 0;
	int len_writes = 0;

	logic [GENE_W-1:0] genes_a [64];
	logic [GENE_W-1:0] genes_b [64];
	int                perm [64];

	always #5 clk = ~clk;

	permutation_order_crossover_core i_dut (
		.clk, .arst_n, .push, .full, .kind, .position, .first_parent_gene,
		.second_parent_gene, .cut_one, .cut_two, .empty, .pop, .child_gene,
		.child_position, .last_gene, .cut_error, .cfg_valid, .cfg_ready, .cfg_data
	);

	crossover_child_checker i_checker (
		.clk, .arst_n, .push, .full, .kind, .position, .first_parent_gene,
		.second_parent_gene, .cut_one, .cut_two, .empty, .pop, .child_gene,
		.child_position, .last_gene, .cut_error, .cfg_valid, .cfg_ready, .cfg_data,
		.mismatches, .pending, .children_checked
	);

	always @(posedge clk)
		pop <= ($urandom_range(99, 0) >= recv_idle);

	task automatic send_item(input logic k, input logic [GENE_W-1:0] p, ga, gb, c1, c2);
		while ($urandom_range(99, 0) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		position <= p;
		first_parent_gene <= ga;
		second_parent_gene <= gb;
		cut_one <= c1;
		cut_two <= c2;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
		mode_items++;
	endtask

	task automatic load_gene_pair(input logic [GENE_W-1:0] p, ga, gb);
		send_item(KIND_LOAD, p, ga, gb, GENE_W'($urandom()), GENE_W'($urandom()));
	endtask

	task automatic run_crossover(input logic [GENE_W-1:0] c1, c2);
		send_item(KIND_START, GENE_W'($urandom()), GENE_W'($urandom()),
			GENE_W'($urandom()), c1, c2);
		crossovers++;
	endtask

	// loads give no result, so allow the back end to drain after the last child
	task automatic settle();
		push <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(input logic [LEN_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		len_writes++;
	endtask

	task automatic shuffle_perm(input int n);
		int i, j, t;
		for (i = 0; i < 64; i++)
			perm[i] = i;
		for (i = n - 1; i > 0; i--) begin
			j = $urandom_range(i, 0);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
	endtask

	// fills positions 0..n-1 in random order; well formed parents share one gene set
	task automatic load_parents(input int n, input bit well_formed);
		int i;
		shuffle_perm(64);
		for (i = 0; i < n; i++)
			genes_a[i] = GENE_W'(perm[i]);
		shuffle_perm(n);
		for (i = 0; i < n; i++)
			genes_b[i] = well_formed ? genes_a[perm[i]] : GENE_W'($urandom());
		if (!well_formed && $urandom_range(1, 0))
			for (i = 0; i < n; i++)
				genes_a[i] = GENE_W'($urandom());
		shuffle_perm(n);
		for (i = 0; i < n; i++)
			load_gene_pair(GENE_W'(perm[i]), genes_a[perm[i]], genes_b[perm[i]]);
	endtask

	task automatic random_start(input int len);
		logic [GENE_W-1:0] c1, c2;
		c1 = GENE_W'($urandom_range(len - 1, 0));
		c2 = GENE_W'($urandom_range(len - 1, 0));
		if (len < 64 && $urandom_range(99, 0) < 15) begin
			if ($urandom_range(1, 0))
				c1 = GENE_W'($urandom_range(63, len));
			else
				c2 = GENE_W'($urandom_range(63, len));
		end
		run_crossover(c1, c2);
	endtask

	task automatic random_phase();
		int len, nseq, s, k;
		len = ($urandom_range(99, 0) < 85) ? $urandom_range(8, 2) : $urandom_range(24, 9);
		set_length(LEN_W'(len));
		nseq = $urandom_range(2, 1);
		for (s = 0; s < nseq; s++) begin
			load_parents(len, $urandom_range(99, 0) < 80);
			// stray loads: overwrite inside the genome or touch positions past it
			if ($urandom_range(99, 0) < 30)
				for (k = $urandom_range(3, 1); k > 0; k--)
					load_gene_pair(GENE_W'($urandom()), GENE_W'($urandom()),
						GENE_W'($urandom()));
			for (k = $urandom_range(3, 1); k > 0; k--)
				random_start(len);
		end
	endtask

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles", LIMIT_CYCLES);
		$display("permutation_order_crossover_core: mismatch");
		$finish;
	end

	initial begin
		int mode, k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest genome: cut order, equal cuts, cut at and far past the length
		set_length(LEN_W'(2));
		load_gene_pair(6'd0, 6'd63, 6'd0);
		load_gene_pair(6'd1, 6'd0, 6'd63);
		run_crossover(6'd0, 6'd1);
		run_crossover(6'd1, 6'd0);
		run_crossover(6'd1, 6'd1);
		run_crossover(6'd0, 6'd0);
		run_crossover(6'd63, 6'd0);
		run_crossover(6'd0, 6'd2);
		// top position, then duplicate genes: slice repeats and a short child
		load_gene_pair(6'd63, 6'd63, 6'd63);
		load_gene_pair(6'd0, 6'd5, 6'd5);
		load_gene_pair(6'd1, 6'd5, 6'd5);
		run_crossover(6'd0, 6'd1);
		run_crossover(6'd1, 6'd1);
		// zero length: every start is rejected
		set_length(LEN_W'(0));
		run_crossover(6'd0, 6'd0);
		run_crossover(6'd63, 6'd63);
		set_length(LEN_W'(3));
		load_gene_pair(6'd2, 6'd42, 6'd21);
		run_crossover(6'd2, 6'd0);
		run_crossover(6'd1, 6'd3);

		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle = 28;
					recv_idle = 58;
				end
				1: begin
					send_idle = 58;
					recv_idle = 28;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			mode_items = 0;
			while (mode_items < 8)
				random_phase();
		end

		// full genome, then a length past the maximum that must act as the maximum
		set_length(LEN_W'(64));
		load_parents(64, 1'b1);
		for (k = 0; k < 3; k++)
			random_start(64);
		set_length(LEN_W'(127));
		run_crossover(6'd63, 6'd0);
		random_start(64);

		settle();
		$display("covered %0d input items: %0d crossovers over %0d length settings",
			items_sent, crossovers, len_writes);
		$display("checked %0d child results under sender and receiver stalls, %0d left over",
			children_checked, pending);
		if (mismatches == 0 && pending == 0)
			$display("permutation_order_crossover_core: match");
		else
			$display("permutation_order_crossover_core: mismatch");
		$finish;
	end

endmodule
